/* rtl/rkd_pkg.sv */
// ----------------------------------------------------------------------------
// rkd_pkg
// shared types and constants for the rsa key derivation block
// ----------------------------------------------------------------------------
package rkd_pkg;

  // default width of the prime factors actually used
  localparam int unsigned PRIME_BITS_DEF = 32;

  // field widths of the streams
  localparam int unsigned FACTOR_W = 32;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned IN_W     = 2 * FACTOR_W + WORD_W;
  localparam int unsigned OUT_W    = 3 * WORD_W;
  localparam int unsigned SHIFT_W  = $clog2(WORD_W);

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_PHI,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_SWAP,
    ST_REDUCE,
    ST_NEGATE,
    ST_DONE
  } rkd_state_t;

endpackage

/* rtl/rsa_key_derivation_top.sv */
// Sequence: accept, multiply n, multiply phi, range checks; rejected inputs go
// straight to the result, otherwise extended Euclid runs (align, one quotient bit
// per subtract step, swap), then the gcd check with reduction and, for a valid key, the sign step.
// Throughput: no new transaction is accepted until the result is loaded; the Euclid
// loop over the one shared 65-bit subtractor (shift-subtract division) sets it.
// Reset: rst_n synchronous, active low; sequencer returns to idle, output empty.
// ----------------------------------------------------------------------------
// rsa_key_derivation_top
// computes n = p*q, phi = (p-1)(q-1) and the private exponent d = e^-1 mod phi
// ----------------------------------------------------------------------------
module rsa_key_derivation_top #(
  parameter int unsigned PRIME_BITS = rkd_pkg::PRIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [rkd_pkg::IN_W-1:0]  in_tdata,   // prime_p, prime_q, public_exp
  // result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rkd_pkg::OUT_W-1:0] out_tdata,  // modulus, totient, private_exp
  output logic                      out_tuser   // status
);
  import rkd_pkg::*;

  localparam logic [FACTOR_W-1:0] PMASK =
    FACTOR_W'((64'd1 << PRIME_BITS) - 64'd1);

  rkd_state_t state_r, state_nxt;

  logic [FACTOR_W-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [WORD_W-1:0]   e_r, e_nxt, n_r, n_nxt, phi_r, phi_nxt;
  logic [WORD_W-1:0]   r0_r, r0_nxt, r1_r, r1_nxt, u0_r, u0_nxt, u1_r, u1_nxt;
  logic [WORD_W-1:0]   rs_r, rs_nxt, us_r, us_nxt, d_r, d_nxt;
  logic [SHIFT_W-1:0]  k_r, k_nxt;
  logic                neg0_r, neg0_nxt, neg1_r, neg1_nxt, bad_r, bad_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]    out_tdata_r, out_tdata_nxt;
  logic                out_tuser_r, out_tuser_nxt;

  // shared unit operands and results
  logic [FACTOR_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0]   mul_y;
  logic [WORD_W-1:0]   sub_a;
  logic [WORD_W:0]     sub_b, sub_d;
  logic                sub_ge;
  logic [FACTOR_W-1:0] pm, qm;
  logic                in_fire, out_load, factor_bad;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // factors minus one, clamped at zero
  assign pm = (p_r == '0) ? '0 : p_r - FACTOR_W'(1);
  assign qm = (q_r == '0) ? '0 : q_r - FACTOR_W'(1);
  assign factor_bad = (p_r[FACTOR_W-1:1] == '0) || (q_r[FACTOR_W-1:1] == '0);

  // operand selection for the shared multiplier and subtractor
  always_comb begin
    mul_a = p_r;
    mul_b = q_r;
    sub_a = r0_r;
    sub_b = {1'b0, rs_r};
    case (state_r)
      ST_MUL_PHI: begin
        mul_a = pm;
        mul_b = qm;
      end
      ST_CHECK: begin
        sub_a = e_r;
        sub_b = {1'b0, phi_r};
      end
      ST_ALIGN: sub_b = {rs_r, 1'b0};
      ST_REDUCE: begin
        sub_a = u0_r;
        sub_b = {1'b0, phi_r};
      end
      ST_NEGATE: begin
        sub_a = phi_r;
        sub_b = {1'b0, u0_r};
      end
      default: ;
    endcase
  end

  assign mul_y  = {32'd0, mul_a} * {32'd0, mul_b};
  assign sub_d  = {1'b0, sub_a} - sub_b;
  assign sub_ge = !sub_d[WORD_W];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_MUL_N;
      ST_MUL_N:   state_nxt = ST_MUL_PHI;
      ST_MUL_PHI: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (factor_bad || e_r[WORD_W-1:1] == '0 || sub_ge) state_nxt = ST_DONE;
        else state_nxt = ST_ALIGN;
      end
      ST_ALIGN:   if (!sub_ge) state_nxt = ST_SUB;
      ST_SUB:     if (k_r == '0) state_nxt = ST_SWAP;
      ST_SWAP:    state_nxt = (r0_r == '0) ? ST_REDUCE : ST_ALIGN;
      ST_REDUCE:  state_nxt = (r0_r == WORD_W'(1)) ? ST_NEGATE : ST_DONE;
      ST_NEGATE:  state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    p_nxt = p_r;   q_nxt = q_r;   e_nxt = e_r;
    n_nxt = n_r;   phi_nxt = phi_r;
    r0_nxt = r0_r; r1_nxt = r1_r; u0_nxt = u0_r; u1_nxt = u1_r;
    rs_nxt = rs_r; us_nxt = us_r; k_nxt = k_r;
    neg0_nxt = neg0_r; neg1_nxt = neg1_r; bad_nxt = bad_r; d_nxt = d_r;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      // capture the transaction, masking unused factor bits
      ST_IDLE: begin
        if (in_fire) begin
          p_nxt = in_tdata[FACTOR_W-1:0] & PMASK;
          q_nxt = in_tdata[2*FACTOR_W-1:FACTOR_W] & PMASK;
          e_nxt = in_tdata[IN_W-1:2*FACTOR_W];
        end
      end
      ST_MUL_N:   n_nxt = mul_y;
      ST_MUL_PHI: phi_nxt = mul_y;
      // range checks, then seed extended euclid
      ST_CHECK: begin
        bad_nxt  = factor_bad || (e_r[WORD_W-1:1] == '0) || sub_ge;
        d_nxt    = '0;
        r0_nxt   = phi_r;
        r1_nxt   = e_r;
        u0_nxt   = '0;
        u1_nxt   = WORD_W'(1);
        neg0_nxt = 1'b0;
        neg1_nxt = 1'b0;
        rs_nxt   = e_r;
        us_nxt   = WORD_W'(1);
        k_nxt    = '0;
      end
      // shift divisor up while twice it still fits under the remainder
      ST_ALIGN: begin
        if (sub_ge) begin
          rs_nxt = {rs_r[WORD_W-2:0], 1'b0};
          us_nxt = {us_r[WORD_W-2:0], 1'b0};
          k_nxt  = k_r + SHIFT_W'(1);
        end
      end
      // one quotient bit: r0 -= r1<<k, u0 += u1<<k
      ST_SUB: begin
        if (sub_ge) begin
          r0_nxt = sub_d[WORD_W-1:0];
          u0_nxt = u0_r + us_r;
        end
        rs_nxt = rs_r >> 1;
        us_nxt = us_r >> 1;
        if (k_r != '0) k_nxt = k_r - SHIFT_W'(1);
      end
      // rotate the remainder and coefficient pairs
      ST_SWAP: begin
        r0_nxt   = r1_r;
        r1_nxt   = r0_r;
        u0_nxt   = u1_r;
        u1_nxt   = u0_r;
        neg0_nxt = neg1_r;
        neg1_nxt = !neg1_r;
        rs_nxt   = r0_r;
        us_nxt   = u0_r;
        k_nxt    = '0;
      end
      // gcd must be one; fold the coefficient below phi
      ST_REDUCE: begin
        if (r0_r != WORD_W'(1)) bad_nxt = 1'b1;
        else if (sub_ge) u0_nxt = sub_d[WORD_W-1:0];
      end
      // apply the coefficient sign
      ST_NEGATE: begin
        d_nxt = (neg0_r && u0_r != '0) ? sub_d[WORD_W-1:0] : u0_r;
      end
      // present the result
      ST_DONE: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(bad_r ? '0 : d_r), phi_r, n_r};
          out_tuser_nxt  = bad_r ? STATUS_BAD : STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r <= p_nxt;   q_r <= q_nxt;   e_r <= e_nxt;
    n_r <= n_nxt;   phi_r <= phi_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; u0_r <= u0_nxt; u1_r <= u1_nxt;
    rs_r <= rs_nxt; us_r <= us_nxt; k_r <= k_nxt;
    neg0_r <= neg0_nxt; neg1_r <= neg1_nxt; bad_r <= bad_nxt; d_r <= d_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // a flagged result never carries an exponent
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[OUT_W-1:2*WORD_W] == '0))
    else $error("flagged result with nonzero private exponent");

  // a good exponent lies in 1 .. phi-1
  a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (out_tdata[OUT_W-1:2*WORD_W] != '0) &&
      (out_tdata[OUT_W-1:2*WORD_W] < out_tdata[2*WORD_W-1:WORD_W]))
    else $error("private exponent out of range");

  // a full division leaves a remainder below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWAP) |-> (r0_r < r1_r))
    else $error("euclid remainder not below divisor");

  // an accepted transaction starts the sequencer
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MUL_N))
    else $error("sequencer did not start on accept");

endmodule

/* tb/tb_rsa_key_derivation_top.sv */
// ----------------------------------------------------------------------------
// tb_rsa_key_derivation_top
// self-checking bench for the rsa key derivation block: a directed table of
// corner keys, then random keys (mostly well-formed, some broken, some noise),
// each result checked field by field against the table or an extended euclid predictor
// ----------------------------------------------------------------------------
module tb_rsa_key_derivation_top;

  import rkd_pkg::*;

  localparam int unsigned PRIME_BITS   = PRIME_BITS_DEF;
  localparam int unsigned RANDOM_KEYS  = 1800;
  localparam int unsigned DRAIN_CYCLES = 450;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned HOLD_AT      = 400;

  typedef struct packed {
    logic [WORD_W-1:0] modulus;
    logic [WORD_W-1:0] totient;
    logic [WORD_W-1:0] private_exp;
    logic              status;
  } rsa_key_t;

  typedef struct {
    logic [FACTOR_W-1:0] p;
    logic [FACTOR_W-1:0] q;
    logic [WORD_W-1:0]   e;
    bit                  typed;
    rsa_key_t            want;
  } key_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               out_tuser;

  rsa_key_t pending_keys[$];
  key_row_t key_rows[$];
  int unsigned mismatches = 0;
  int unsigned keys_sent  = 0;
  bit          steady     = 1'b0;

  rsa_key_derivation_top #(
    .PRIME_BITS(PRIME_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop
  initial begin
    #60000000;
    $display("rsa_key_derivation_top verification failed");
    $finish;
  end

  // predictor: n, phi and the inverse of e modulo phi by extended euclid,
  // coefficient kept as magnitude plus sign parity
  function automatic rsa_key_t derive_key(logic [FACTOR_W-1:0] p_in,
                                          logic [FACTOR_W-1:0] q_in,
                                          logic [WORD_W-1:0] e);
    logic [WORD_W-1:0] mask, p, q, pm, qm, phi, d;
    logic [WORD_W-1:0] r0, r1, r2, u0, u1, u2, qt;
    bit neg0, neg1, bad;
    rsa_key_t k;
    mask = (PRIME_BITS >= WORD_W) ? '1 : ((64'd1 << PRIME_BITS) - 64'd1);
    p    = WORD_W'(p_in) & mask;
    q    = WORD_W'(q_in) & mask;
    pm   = (p > 0) ? p - 64'd1 : 64'd0;
    qm   = (q > 0) ? q - 64'd1 : 64'd0;
    phi  = pm * qm;
    d    = '0;
    bad  = 1'b0;
    if (p < 2 || q < 2 || e < 2 || e >= phi) begin
      bad = 1'b1;
    end else begin
      r0 = phi; r1 = e; u0 = 64'd0; u1 = 64'd1; neg0 = 1'b0; neg1 = 1'b0;
      while (r1 != 0) begin
        qt   = r0 / r1;
        r2   = r0 - qt * r1;
        u2   = u0 + qt * u1;
        r0   = r1;  r1 = r2;
        u0   = u1;  u1 = u2;
        neg0 = neg1; neg1 = !neg1;
      end
      if (r0 != 64'd1) begin
        bad = 1'b1;
      end else begin
        u0 = u0 % phi;
        d  = (neg0 && u0 != 0) ? phi - u0 : u0;
      end
    end
    k.modulus     = p * q;
    k.totient     = phi;
    k.private_exp = bad ? 64'd0 : d;
    k.status      = bad ? STATUS_BAD : STATUS_OK;
    return k;
  endfunction

  task automatic add_row(logic [FACTOR_W-1:0] p, logic [FACTOR_W-1:0] q,
                         logic [WORD_W-1:0] e, bit typed,
                         logic [WORD_W-1:0] n, logic [WORD_W-1:0] phi,
                         logic [WORD_W-1:0] d, logic st);
    key_row_t r;
    r.p = p; r.q = q; r.e = e; r.typed = typed;
    r.want = '{modulus: n, totient: phi, private_exp: d, status: st};
    key_rows.push_back(r);
  endtask

  // offer one key with a random gap, wait for the transaction, queue the result
  task automatic send_key(logic [FACTOR_W-1:0] p, logic [FACTOR_W-1:0] q,
                          logic [WORD_W-1:0] e, bit typed, rsa_key_t want);
    while (!steady && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {e, q, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_keys.push_back(typed ? want : derive_key(p, q, e));
    keys_sent++;
  endtask

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // odd factor of the given bit length, top bit set
  function automatic logic [FACTOR_W-1:0] odd_factor(int unsigned w);
    logic [FACTOR_W-1:0] v;
    v = $urandom;
    if (w < FACTOR_W) v &= (32'd1 << w) - 32'd1;
    return v | (32'd1 << (w - 1)) | 32'd1;
  endfunction

  function automatic int unsigned factor_width();
    return ($urandom_range(9) < 7) ? $urandom_range(4, 16) : $urandom_range(17, 32);
  endfunction

  task automatic random_key(output logic [FACTOR_W-1:0] p,
                            output logic [FACTOR_W-1:0] q,
                            output logic [WORD_W-1:0] e);
    int unsigned kind;
    logic [WORD_W-1:0] phi;
    kind = $urandom_range(99);
    p    = odd_factor(factor_width());
    q    = odd_factor(factor_width());
    phi  = WORD_W'(p - 1) * WORD_W'(q - 1);
    if (kind < 70) begin
      // well-formed: odd e inside the range, usually coprime
      e = (64'd3 + rand64() % (phi - 64'd3)) | 64'd1;
    end else if (kind < 82) begin
      // broken: even e, e at or above phi, or e below 2
      case ($urandom_range(3))
        0:       e = (64'd2 + rand64() % (phi - 64'd2)) & ~64'd1;
        1:       e = phi;
        2:       e = phi + rand64() % 64'd1000;
        default: e = 64'($urandom_range(1));
      endcase
    end else begin
      // noise over the whole field range
      p = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : 32'($urandom);
      q = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : 32'($urandom);
      e = ($urandom_range(1) == 0) ? rand64() : 64'($urandom_range(0, 70000));
    end
  endtask

  task automatic note_mismatch(string what, logic [WORD_W-1:0] want,
                               logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h", what, want, got);
  endtask

  // result side: checks each transaction, random stalls, one long hold-off
  initial begin : result_side
    int unsigned hold_left;
    bit          held;
    rsa_key_t    want;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_keys.size() == 0) begin
          note_mismatch("unexpected result", '0, out_tdata[WORD_W-1:0]);
        end else begin
          want = pending_keys.pop_front();
          if (out_tdata[WORD_W-1:0] !== want.modulus)
            note_mismatch("modulus", want.modulus, out_tdata[WORD_W-1:0]);
          if (out_tdata[2*WORD_W-1:WORD_W] !== want.totient)
            note_mismatch("totient", want.totient, out_tdata[2*WORD_W-1:WORD_W]);
          if (out_tdata[3*WORD_W-1:2*WORD_W] !== want.private_exp)
            note_mismatch("private_exp", want.private_exp,
                          out_tdata[3*WORD_W-1:2*WORD_W]);
          if (out_tuser !== want.status)
            note_mismatch("status", WORD_W'(want.status), WORD_W'(out_tuser));
        end
      end
      if (!held && keys_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 9);
      end
    end
  end

  // input side: reset, directed table, random keys, drain
  initial begin : key_source
    logic [FACTOR_W-1:0] p, q;
    logic [WORD_W-1:0]   e;
    rsa_key_t            none;
    none = '0;

    // factor zero and factor one
    add_row(0, 7, 3, 1, 0, 0, 0, STATUS_BAD);
    add_row(11, 0, 3, 1, 0, 0, 0, STATUS_BAD);
    add_row(1, 13, 5, 1, 13, 0, 0, STATUS_BAD);
    add_row(17, 1, 5, 1, 17, 0, 0, STATUS_BAD);
    // empty exponent range
    add_row(2, 2, 3, 1, 4, 1, 0, STATUS_BAD);
    add_row(2, 3, 1, 1, 6, 2, 0, STATUS_BAD);
    // exponent out of range
    add_row(3, 5, 0, 1, 15, 8, 0, STATUS_BAD);
    add_row(3, 5, 1, 1, 15, 8, 0, STATUS_BAD);
    add_row(3, 5, 8, 1, 15, 8, 0, STATUS_BAD);
    add_row(3, 5, '1, 1, 15, 8, 0, STATUS_BAD);
    // not coprime
    add_row(3, 5, 2, 1, 15, 8, 0, STATUS_BAD);
    add_row(61, 53, 4, 1, 3233, 3120, 0, STATUS_BAD);
    // small valid keys
    add_row(3, 5, 3, 1, 15, 8, 3, STATUS_OK);
    add_row(3, 5, 7, 1, 15, 8, 7, STATUS_OK);
    add_row(5, 7, 23, 1, 35, 24, 23, STATUS_OK);
    add_row(61, 53, 17, 1, 3233, 3120, 2753, STATUS_OK);
    // largest factors: e = phi-1 is its own inverse, e = phi is rejected
    add_row('1, '1, 64'hFFFF_FFFC_0000_0003, 1, 64'hFFFF_FFFE_0000_0001,
            64'hFFFF_FFFC_0000_0004, 64'hFFFF_FFFC_0000_0003, STATUS_OK);
    add_row('1, '1, 64'hFFFF_FFFC_0000_0004, 1, 64'hFFFF_FFFE_0000_0001,
            64'hFFFF_FFFC_0000_0004, 0, STATUS_BAD);
    add_row('1, '1, 3, 0, 0, 0, 0, STATUS_OK);
    add_row('1, '1, 65537, 0, 0, 0, 0, STATUS_OK);
    add_row('1, 2, 64'hFFFF_FFFD, 0, 0, 0, 0, STATUS_OK);
    // factors that are not prime, then other large factors
    add_row(4, 9, 5, 0, 0, 0, 0, STATUS_OK);
    add_row(32'h8000_0000, 3, 64'h7FFF_FFFF, 0, 0, 0, 0, STATUS_OK);
    add_row(32'hDEAD_BEEF, 32'h1234_5679, 65537, 0, 0, 0, 0, STATUS_OK);
    add_row(65537, 65539, 65537, 0, 0, 0, 0, STATUS_OK);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (key_rows[i])
      send_key(key_rows[i].p, key_rows[i].q, key_rows[i].e,
               key_rows[i].typed, key_rows[i].want);

    for (int i = 0; i < RANDOM_KEYS; i++) begin
      steady = (i >= 900 && i < 1200);
      random_key(p, q, e);
      send_key(p, q, e, 1'b0, none);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("rsa_key_derivation_top verification clean");
    else
      $display("rsa_key_derivation_top verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/rkd_pkg.sv
rtl/rsa_key_derivation_top.sv
tb/tb_rsa_key_derivation_top.sv
